// ===== src/i2c_xyz_frame_receiver_top_assert.svh =====
// Assertion macros shared by the checker of the frame receiver.
`ifndef I2C_XYZ_FRAME_RECEIVER_TOP_ASSERT_SVH
`define I2C_XYZ_FRAME_RECEIVER_TOP_ASSERT_SVH

// A property that is checked only outside reset.
`define IXFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A property that is checked at every edge, reset included.
`define IXFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ixfr_pkg.sv =====
// Package of the frame receiver: constants, event codes and shared types.
`timescale 1ns / 1ps

package ixfr_pkg;

  localparam int unsigned FRAME_BYTES = 12;
  localparam int unsigned INDEX_W     = 4;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned RATE_W      = 23;
  localparam int unsigned CNT_W       = 8;

  // Reciprocal of 1000 scaled by two to the power RECIP_SHIFT, rounded up.
  // It is exact for every magnitude up to two to the power 31.
  localparam int unsigned RECIP_SHIFT = 41;
  localparam logic [WORD_W-1:0] RECIP_1000 = 32'd2199023256;

  typedef enum logic [2:0] {
    EV_START = 3'd0,
    EV_BYTE  = 3'd1,
    EV_STOP  = 3'd2,
    EV_NACK  = 3'd3,
    EV_BERR  = 3'd4,
    EV_ARLO  = 3'd5
  } ev_t;

  typedef struct packed {
    logic              sign;
    logic [WORD_W-1:0] mag;
  } word_t;

  typedef struct packed {
    logic             frame_ok;
    word_t            x;
    word_t            y;
    word_t            z;
    logic [CNT_W-1:0] good;
    logic [CNT_W-1:0] bad;
    logic             led;
  } frame_t;

endpackage

// ===== src/ixfr_assembler.sv =====
// Frame assembly: event decoding, byte store, counters and the frame register.
`timescale 1ns / 1ps

module ixfr_assembler (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_req_type,
  input  logic [7:0]           in_rx_byte,
  input  logic                 down_free,
  output logic                 frame_valid,
  output ixfr_pkg::frame_t     frame
);

  logic [7:0]                     store_r [ixfr_pkg::FRAME_BYTES];
  logic [ixfr_pkg::INDEX_W-1:0]   index_r;
  logic                           err_r;
  logic [ixfr_pkg::CNT_W-1:0]     good_r;
  logic [ixfr_pkg::CNT_W-1:0]     bad_r;
  logic                           led_r;
  logic                           frame_valid_r;
  ixfr_pkg::frame_t               frame_r;
  ixfr_pkg::frame_t               frame_nxt;
  logic                           accept;
  logic                           take;
  logic                           ok;
  ixfr_pkg::ev_t                  ev;

  function automatic ixfr_pkg::word_t make_word(input logic [31:0] w);
    ixfr_pkg::word_t r;
    r.sign = w[31];
    r.mag  = w[31] ? (~w + 32'd1) : w;
    return r;
  endfunction

  assign take     = frame_valid_r && down_free;
  assign in_ready = !frame_valid_r || down_free;
  assign accept   = in_valid && in_ready;
  assign ev       = ixfr_pkg::ev_t'(in_req_type);
  assign ok       = !err_r && (index_r == ixfr_pkg::INDEX_W'(ixfr_pkg::FRAME_BYTES));

  always_comb begin
    frame_nxt.frame_ok = ok;
    frame_nxt.x    = make_word({store_r[3], store_r[2], store_r[1], store_r[0]});
    frame_nxt.y    = make_word({store_r[7], store_r[6], store_r[5], store_r[4]});
    frame_nxt.z    = make_word({store_r[11], store_r[10], store_r[9], store_r[8]});
    frame_nxt.good = ok ? good_r + 8'd1 : good_r;
    frame_nxt.bad  = ok ? bad_r : bad_r + 8'd1;
    frame_nxt.led  = led_r ^ ok;
    if (!ok) begin
      frame_nxt.x = '0;
      frame_nxt.y = '0;
      frame_nxt.z = '0;
    end
  end

  // The byte store has no reset: a frame passes only once all entries are written.
  always_ff @(posedge clk) begin
    if (accept && ev == ixfr_pkg::EV_BYTE &&
        index_r < ixfr_pkg::INDEX_W'(ixfr_pkg::FRAME_BYTES)) begin
      store_r[index_r] <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r       <= '0;
      err_r         <= 1'b0;
      good_r        <= '0;
      bad_r         <= '0;
      led_r         <= 1'b0;
      frame_valid_r <= 1'b0;
    end else begin
      // The frame register stays full unless it is taken, and a new stop refills it.
      frame_valid_r <= (frame_valid_r && !take) ||
                       (accept && ev == ixfr_pkg::EV_STOP);
      if (accept) begin
        unique case (ev) inside
          ixfr_pkg::EV_START: begin
            index_r <= '0;
            err_r   <= 1'b0;
          end
          ixfr_pkg::EV_BYTE: begin
            if (index_r < ixfr_pkg::INDEX_W'(ixfr_pkg::FRAME_BYTES)) begin
              index_r <= index_r + 4'd1;
            end else begin
              err_r <= 1'b1;
            end
          end
          ixfr_pkg::EV_NACK, ixfr_pkg::EV_BERR, ixfr_pkg::EV_ARLO: begin
            err_r <= 1'b1;
          end
          ixfr_pkg::EV_STOP: begin
            good_r <= frame_nxt.good;
            bad_r  <= frame_nxt.bad;
            led_r  <= frame_nxt.led;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ev == ixfr_pkg::EV_STOP) begin
      frame_r <= frame_nxt;
    end
  end

  assign frame_valid = frame_valid_r;
  assign frame       = frame_r;

endmodule

// ===== src/ixfr_rate_lane.sv =====
// One division lane: signed magnitude divided by 1000 through a reciprocal product.
`timescale 1ns / 1ps

module ixfr_rate_lane (
  input  ixfr_pkg::word_t                   wd,
  output logic signed [ixfr_pkg::RATE_W-1:0] rate
);

  logic [2*ixfr_pkg::WORD_W-1:0] prod;
  logic [ixfr_pkg::RATE_W-1:0]   q;

  assign prod = (2*ixfr_pkg::WORD_W)'(wd.mag) * (2*ixfr_pkg::WORD_W)'(ixfr_pkg::RECIP_1000);
  assign q    = prod[ixfr_pkg::RECIP_SHIFT +: ixfr_pkg::RATE_W];
  // Truncation toward zero: divide the magnitude, then restore the sign.
  assign rate = signed'(wd.sign ? (ixfr_pkg::RATE_W'(0) - q) : q);

endmodule

// ===== src/i2c_xyz_frame_receiver_top.sv =====
// A stop word loads the frame register; the frame then moves on into the result register, which drives out_valid.
// Throughput: one event word per cycle; the input stalls only while the frame register
// and the result register both hold a result and out_ready is low.
// The frame register and the result register each hold one stop, so stops flow at one
// per cycle while out_ready stays high.
// Reset (rst_n low, synchronous) clears the index, error flag, counters, LED and valids.
`timescale 1ns / 1ps

module i2c_xyz_frame_receiver_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         in_req_type,
  input  logic [7:0]                         in_rx_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_frame_ok,
  output logic signed [ixfr_pkg::RATE_W-1:0] out_x_rate,
  output logic signed [ixfr_pkg::RATE_W-1:0] out_y_rate,
  output logic signed [ixfr_pkg::RATE_W-1:0] out_z_rate,
  output logic [ixfr_pkg::CNT_W-1:0]         out_good_frames,
  output logic [ixfr_pkg::CNT_W-1:0]         out_bad_frames,
  output logic                               out_led_level
);

  // The assembler updates the frame state on every accepted word. A stop word
  // also loads the frame register with the three words in sign and magnitude
  // form together with the counters as they stand after that stop.
  logic                               frame_valid;
  ixfr_pkg::frame_t                   frame;
  logic                               out_free;

  logic signed [ixfr_pkg::RATE_W-1:0] x_nxt;
  logic signed [ixfr_pkg::RATE_W-1:0] y_nxt;
  logic signed [ixfr_pkg::RATE_W-1:0] z_nxt;

  logic                               out_valid_r;
  logic                               frame_ok_r;
  logic signed [ixfr_pkg::RATE_W-1:0] x_r;
  logic signed [ixfr_pkg::RATE_W-1:0] y_r;
  logic signed [ixfr_pkg::RATE_W-1:0] z_r;
  logic [ixfr_pkg::CNT_W-1:0]         good_r;
  logic [ixfr_pkg::CNT_W-1:0]         bad_r;
  logic                               led_r;

  // The result register is free when empty or when its word leaves this cycle.
  assign out_free = !out_valid_r || out_ready;

  ixfr_assembler u_asm (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_rx_byte  (in_rx_byte),
    .down_free   (out_free),
    .frame_valid (frame_valid),
    .frame       (frame)
  );

  // Three independent division lanes, one per axis, sit between the frame
  // register and the result register.
  ixfr_rate_lane u_lane_x (.wd(frame.x), .rate(x_nxt));
  ixfr_rate_lane u_lane_y (.wd(frame.y), .rate(y_nxt));
  ixfr_rate_lane u_lane_z (.wd(frame.z), .rate(z_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= frame_valid;
    end
  end

  // Payload registers carry no reset; they load whenever a frame moves on.
  always_ff @(posedge clk) begin
    if (out_free && frame_valid) begin
      frame_ok_r <= frame.frame_ok;
      x_r        <= x_nxt;
      y_r        <= y_nxt;
      z_r        <= z_nxt;
      good_r     <= frame.good;
      bad_r      <= frame.bad;
      led_r      <= frame.led;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_ok    = frame_ok_r;
  assign out_x_rate      = x_r;
  assign out_y_rate      = y_r;
  assign out_z_rate      = z_r;
  assign out_good_frames = good_r;
  assign out_bad_frames  = bad_r;
  assign out_led_level   = led_r;

endmodule

// ===== src/ixfr_checker.sv =====
// Port-level checker of the frame receiver and its bind to the top level.
`timescale 1ns / 1ps
`include "i2c_xyz_frame_receiver_top_assert.svh"

module ixfr_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [2:0]                         in_req_type,
  input logic [7:0]                         in_rx_byte,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_frame_ok,
  input logic signed [ixfr_pkg::RATE_W-1:0] out_x_rate,
  input logic signed [ixfr_pkg::RATE_W-1:0] out_y_rate,
  input logic signed [ixfr_pkg::RATE_W-1:0] out_z_rate,
  input logic [ixfr_pkg::CNT_W-1:0]         out_good_frames,
  input logic [ixfr_pkg::CNT_W-1:0]         out_bad_frames,
  input logic                               out_led_level
);

  logic [10:0]                                     in_word;
  logic [3*ixfr_pkg::RATE_W+2*ixfr_pkg::CNT_W+1:0] out_word;
  logic                                            stop_taken;

  assign in_word    = {in_req_type, in_rx_byte};
  assign out_word   = {out_frame_ok, out_x_rate, out_y_rate, out_z_rate,
                       out_good_frames, out_bad_frames, out_led_level};
  assign stop_taken = in_valid && in_ready && in_req_type == ixfr_pkg::EV_STOP;

  // A waiting event word holds.
  `IXFR_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_word), "event word changed")

  // A stalled result word holds.
  `IXFR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word), "stalled result word changed")

  // A failed frame reports zero rates.
  `IXFR_ASSERT(a_fail_zero, out_valid && !out_frame_ok |-> out_x_rate == 0 && out_y_rate == 0 && out_z_rate == 0, "failed frame with non-zero rates")

  // No result word is shown in the cycle after reset.
  `IXFR_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid, "result valid after reset")

  // With both registers empty, a word that is not a stop cannot bring a result.
  `IXFR_ASSERT(a_no_spurious, !out_valid && !stop_taken ##1 !out_valid |=> !out_valid, "result word without a stop")

endmodule

bind i2c_xyz_frame_receiver_top ixfr_checker u_ixfr_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the twelve-byte rate frame receiver.
`timescale 1ns / 1ps

module tb;
  import ixfr_pkg::*;

  // The two spare event codes have no meaning and must leave the receiver untouched.
  localparam logic [2:0] EV_SPARE_6 = 3'd6;
  localparam logic [2:0] EV_SPARE_7 = 3'd7;

  // One report word as it leaves the receiver.
  typedef struct packed {
    logic                     frame_ok;
    logic signed [RATE_W-1:0] x_rate;
    logic signed [RATE_W-1:0] y_rate;
    logic signed [RATE_W-1:0] z_rate;
    logic [CNT_W-1:0]         good;
    logic [CNT_W-1:0]         bad;
    logic                     led;
  } rate_report_t;

  // One row of the directed script. Rows with known_report set carry the report
  // that is typed in by hand; all other reports come from the frame predictor.
  typedef struct packed {
    logic [2:0]   code;
    logic [7:0]   data;
    logic         known_report;
    rate_report_t report;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_req_type = 3'd0;
  logic [7:0] in_rx_byte = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_frame_ok;
  logic signed [RATE_W-1:0] out_x_rate;
  logic signed [RATE_W-1:0] out_y_rate;
  logic signed [RATE_W-1:0] out_z_rate;
  logic [CNT_W-1:0] out_good_frames;
  logic [CNT_W-1:0] out_bad_frames;
  logic out_led_level;

  i2c_xyz_frame_receiver_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_ok    (out_frame_ok),
    .out_x_rate      (out_x_rate),
    .out_y_rate      (out_y_rate),
    .out_z_rate      (out_z_rate),
    .out_good_frames (out_good_frames),
    .out_bad_frames  (out_bad_frames),
    .out_led_level   (out_led_level)
  );

  // Free-running clock with an 8 ns period.
  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state: a private copy of everything the receiver remembers.
  logic [7:0]       frame_bytes [FRAME_BYTES];
  logic [3:0]       byte_count;
  logic             frame_fault;
  logic [CNT_W-1:0] good_total;
  logic [CNT_W-1:0] bad_total;
  logic             led_state;

  rate_report_t pending_reports [$];
  script_row_t  script [$];
  rate_report_t oldest_report;

  int mismatches = 0;
  int words_sent = 0;
  int send_gap = 0;     // chance, in percent, that the sender idles before a word
  int recv_stall = 0;   // chance, in percent, that out_ready is low in a cycle

  function automatic rate_report_t make_report(input logic ok,
                                               input logic signed [RATE_W-1:0] x,
                                               input logic signed [RATE_W-1:0] y,
                                               input logic signed [RATE_W-1:0] z,
                                               input logic [CNT_W-1:0] g,
                                               input logic [CNT_W-1:0] b,
                                               input logic l);
    rate_report_t r;
    r.frame_ok = ok;
    r.x_rate   = x;
    r.y_rate   = y;
    r.z_rate   = z;
    r.good     = g;
    r.bad      = b;
    r.led      = l;
    return r;
  endfunction

  // Little-endian signed word starting at base, divided by 1000. SystemVerilog
  // signed division truncates toward zero, exactly as the receiver must.
  function automatic logic signed [RATE_W-1:0] rate_of(input int base);
    logic signed [31:0] w;
    int q;
    w = {frame_bytes[base+3], frame_bytes[base+2], frame_bytes[base+1], frame_bytes[base]};
    q = w / 1000;
    return q[RATE_W-1:0];
  endfunction

  // Applies one bus event to the predictor state. Returns 1 when the event is a
  // stop, in which case report holds what the receiver must emit for it.
  function automatic bit predict_event(input logic [2:0] code, input logic [7:0] data,
                                       output rate_report_t report);
    bit emits;
    emits  = 1'b0;
    report = '0;
    case (code)
      EV_START: begin
        byte_count  = '0;
        frame_fault = 1'b0;
      end
      EV_BYTE: begin
        if (byte_count < FRAME_BYTES) begin
          frame_bytes[byte_count] = data;
          byte_count = byte_count + 4'd1;
        end else begin
          frame_fault = 1'b1;
        end
      end
      EV_NACK, EV_BERR, EV_ARLO: frame_fault = 1'b1;
      EV_STOP: begin
        emits = 1'b1;
        // The index is deliberately left alone, so a repeated stop re-checks the frame.
        if (!frame_fault && byte_count == FRAME_BYTES) begin
          good_total = good_total + 8'd1;
          led_state  = ~led_state;
          report = make_report(1'b1, rate_of(0), rate_of(4), rate_of(8),
                               good_total, bad_total, led_state);
        end else begin
          bad_total = bad_total + 8'd1;
          report = make_report(1'b0, '0, '0, '0, good_total, bad_total, led_state);
        end
      end
      default: ;
    endcase
    return emits;
  endfunction

  task automatic add_row(input logic [2:0] code, input logic [7:0] data,
                         input logic known = 1'b0, input rate_report_t report = '0);
    script_row_t r;
    r.code         = code;
    r.data         = data;
    r.known_report = known;
    r.report       = report;
    script.push_back(r);
  endtask

  // Offers one event word and waits for it to be taken. Every call starts and
  // ends just after a rising edge, so in_valid sees one assignment per time step.
  task automatic send_event(input logic [2:0] code, input logic [7:0] data,
                            input logic known = 1'b0, input rate_report_t report = '0);
    rate_report_t predicted;
    if ($urandom_range(0, 99) < send_gap) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap);
    end
    in_valid    <= 1'b1;
    in_req_type <= code;
    in_rx_byte  <= data;
    do @(posedge clk); while (!in_ready);
    // The word was taken at this edge.
    words_sent++;
    if (predict_event(code, data, predicted))
      pending_reports.push_back(known ? report : predicted);
  endtask

  // Bytes lean towards the extremes now and then so that words reach their limits.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic good_frame(input bit with_start);
    if (with_start)
      send_event(EV_START, pick_byte());
    repeat (FRAME_BYTES) send_event(EV_BYTE, pick_byte());
    send_event(EV_STOP, pick_byte());
  endtask

  task automatic stop_burst(input int n);
    repeat (n) send_event(EV_STOP, pick_byte());
  endtask

  // One random transfer. Most are well formed; the rest are short, long, broken
  // by an error event, missing their start, plain noise or runs of stops.
  task automatic play_transfer();
    int kind;
    int n;
    int fault_at;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      good_frame(1'b1);
    end else if (kind < 64) begin
      good_frame(1'b0);
    end else if (kind < 71) begin
      send_event(EV_START, pick_byte());
      repeat ($urandom_range(0, FRAME_BYTES - 1)) send_event(EV_BYTE, pick_byte());
      send_event(EV_STOP, pick_byte());
    end else if (kind < 78) begin
      send_event(EV_START, pick_byte());
      repeat ($urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 3))
        send_event(EV_BYTE, pick_byte());
      send_event(EV_STOP, pick_byte());
    end else if (kind < 87) begin
      send_event(EV_START, pick_byte());
      fault_at = $urandom_range(0, FRAME_BYTES);
      for (n = 0; n < FRAME_BYTES; n++) begin
        if (n == fault_at)
          send_event(3'($urandom_range(EV_NACK, EV_ARLO)), pick_byte());
        send_event(EV_BYTE, pick_byte());
      end
      if (fault_at == FRAME_BYTES)
        send_event(3'($urandom_range(EV_NACK, EV_ARLO)), pick_byte());
      send_event(EV_STOP, pick_byte());
    end else if (kind < 94) begin
      repeat ($urandom_range(1, 4)) send_event(3'($urandom_range(0, 7)), pick_byte());
    end else begin
      stop_burst($urandom_range(1, 4));
    end
  endtask

  // Drops in_valid and holds off until every report owed so far has arrived.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result side. Reports are compared at the edge that takes them, against the
  // oldest one still owed; out_ready is then redrawn for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("report word arrived with none expected");
        mismatches++;
      end else begin
        oldest_report = pending_reports.pop_front();
        check_field("frame_ok", oldest_report.frame_ok, out_frame_ok);
        check_field("x_rate", $signed(oldest_report.x_rate), $signed(out_x_rate));
        check_field("y_rate", $signed(oldest_report.y_rate), $signed(out_y_rate));
        check_field("z_rate", $signed(oldest_report.z_rate), $signed(out_z_rate));
        check_field("good_frames", oldest_report.good, out_good_frames);
        check_field("bad_frames", oldest_report.bad, out_bad_frames);
        check_field("led_level", oldest_report.led, out_led_level);
      end
    end
    if (rst_n)
      out_ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  // Stimulus: reset, the directed script, then four random phases with
  // different amounts of idling on each side.
  initial begin
    logic [7:0] limit_frame [FRAME_BYTES];
    int phase;
    int guard;

    // Bytes 0..3 give the largest positive word, 4..7 the most negative one and
    // 8..11 minus one thousand, which must come out as minus one.
    limit_frame = '{8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h80,
                    8'h18, 8'hFC, 8'hFF, 8'hFF};
    for (int i = 0; i < FRAME_BYTES; i++) frame_bytes[i] = 8'h00;
    byte_count  = '0;
    frame_fault = 1'b0;
    good_total  = '0;
    bad_total   = '0;
    led_state   = 1'b0;

    // A stop straight after reset, with no start before it, is a failed frame.
    add_row(EV_STOP, 8'h00, 1'b1, make_report(1'b0, '0, '0, '0, 8'd0, 8'd1, 1'b0));
    add_row(EV_START, 8'hFF);
    foreach (limit_frame[i]) add_row(EV_BYTE, limit_frame[i]);
    add_row(EV_STOP, 8'h00, 1'b1,
            make_report(1'b1, 23'sd2147483, -23'sd2147483, -23'sd1, 8'd1, 8'd1, 1'b1));
    // A repeated stop checks the same twelve bytes again and passes once more.
    add_row(EV_STOP, 8'hFF, 1'b1,
            make_report(1'b1, 23'sd2147483, -23'sd2147483, -23'sd1, 8'd2, 8'd1, 1'b0));
    // A thirteenth byte spoils the frame.
    add_row(EV_BYTE, 8'hAA);
    add_row(EV_STOP, 8'h00, 1'b1, make_report(1'b0, '0, '0, '0, 8'd2, 8'd2, 1'b0));
    add_row(EV_SPARE_6, 8'h55);
    add_row(EV_START, 8'h00);
    add_row(EV_NACK, 8'h00);
    add_row(EV_BERR, 8'hFF);
    add_row(EV_ARLO, 8'h00);
    add_row(EV_SPARE_7, 8'hFF);
    add_row(EV_STOP, 8'h00, 1'b1, make_report(1'b0, '0, '0, '0, 8'd2, 8'd3, 1'b0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i])
      send_event(script[i].code, script[i].data, script[i].known_report, script[i].report);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap = 0;  recv_stall = 0;  end
        1: begin send_gap = 87; recv_stall = 0;  end
        2: begin send_gap = 0;  recv_stall = 87; end
        default: begin send_gap = 19; recv_stall = 19; end
      endcase
      if (phase == 0) begin
        // Drive both counters through their wrap: one good frame and a long run
        // of repeated stops for the good count, then an error and another run.
        good_frame(1'b1);
        stop_burst(260);
        send_event(EV_NACK, pick_byte());
        stop_burst(260);
      end
      while (words_sent < 25 + 475 * (phase + 1))
        play_transfer();
      // Let every owed report come out before the next phase begins.
      wait_for_drain();
    end

    in_valid <= 1'b0;
    guard = 0;
    while (pending_reports.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    // Wait on after the drain to catch any stray report.
    repeat (8) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d report words never arrived", pending_reports.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legitimate run.
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ixfr_pkg.sv
src/ixfr_assembler.sv
src/ixfr_rate_lane.sv
src/i2c_xyz_frame_receiver_top.sv
src/ixfr_checker.sv
tb/tb.sv
